FILE: hw/rtl/two_stage_svf_lowpass_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_STAGE_SVF_LOWPASS_CORE_ASSERT_SVH
`define TWO_STAGE_SVF_LOWPASS_CORE_ASSERT_SVH

// check consequent in the same cycle as the antecedent
`define SVFLP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check consequent in the cycle after the antecedent
`define SVFLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/svflp_pkg.sv
// ----------------------------------------------------------------------------
// svflp_pkg
// Command types and sequencing constants for the two-section SVF lowpass.
// ----------------------------------------------------------------------------
package svflp_pkg;

	typedef enum logic [1:0] {
		A_CUT,
		A_DAMP,
		A_F2,
		A_Q2
	} a_sel_t;

	typedef enum logic [2:0] {
		B_BAND1,
		B_BAND2,
		B_HI,
		B_KF2,
		B_KQ2
	} b_sel_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOW,
		OP_HIGH,
		OP_F2,
		OP_Q2,
		OP_BAND
	} op_t;

	typedef enum logic {
		SEC_ONE,
		SEC_TWO
	} sec_t;

	typedef struct packed {
		logic   load;
		a_sel_t a_sel;
		b_sel_t b_sel;
		op_t    op;
		sec_t   sec;
	} cmd_t;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CUTOFF,
		REG_DAMPING
	} cfg_reg_t;

	localparam int              STEP_W    = 4;
	localparam logic [STEP_W-1:0] STEP_HOLD = 4'd9;
	localparam logic [STEP_W-1:0] STEP_LAST = 4'd11;

endpackage

FILE: hw/rtl/svflp_sample_if.sv
// ----------------------------------------------------------------------------
// svflp_sample_if
// Input sample channel: valid/ready with sample and clear flag.
// ----------------------------------------------------------------------------
interface svflp_sample_if #(
	parameter int FRAC_BITS = 16
);
	logic                       valid;
	logic                       ready;
	logic signed [FRAC_BITS:0]  sample_in;
	logic                       clear_state;

	modport source (output valid, output sample_in, output clear_state, input ready);
	modport sink (input valid, input sample_in, input clear_state, output ready);
endinterface

FILE: hw/rtl/svflp_result_if.sv
// ----------------------------------------------------------------------------
// svflp_result_if
// Output result channel: valid/ready with the lowpass value.
// ----------------------------------------------------------------------------
interface svflp_result_if #(
	parameter int FRAC_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [FRAC_BITS+1:0]  lowpass_out;

	modport source (output valid, output lowpass_out, input ready);
	modport sink (input valid, input lowpass_out, output ready);
endinterface

FILE: hw/rtl/svflp_datapath.sv
// ----------------------------------------------------------------------------
// svflp_datapath
// Coefficient registers, integrators, shared multiplier with rounding stage,
// and the accumulate/clamp logic of both filter sections.
// ----------------------------------------------------------------------------
module svflp_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  svflp_pkg::cmd_t                       cmd,
	input  logic                                  cfg_we,
	input  logic [svflp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [FRAC_BITS:0]                    cfg_data,
	input  logic signed [FRAC_BITS:0]             sample_in,
	input  logic                                  clear_state,
	output logic signed [FRAC_BITS+1:0]           lowpass_out
);
	localparam int OW = FRAC_BITS + 2;
	localparam int CW = FRAC_BITS + 3;
	localparam int AW = FRAC_BITS + 6;
	localparam int PW = CW + AW;

	localparam longint ONE      = 64'sd1 <<< FRAC_BITS;
	localparam longint KF2      = (95 * ONE + 50) / 100;
	localparam longint KQ2      = (103 * ONE + 50) / 100;
	localparam longint LIMIT    = 3 * (ONE / 2);
	localparam longint CUT_RST  = (1486 * ONE) / 65536;
	localparam longint DAMP_RST = (46334 * ONE) / 65536;

	localparam logic signed [AW-1:0] KF2_A   = AW'(KF2);
	localparam logic signed [AW-1:0] KQ2_A   = AW'(KQ2);
	localparam logic signed [OW-1:0] LIM_P   = OW'(LIMIT);
	localparam logic signed [OW-1:0] LIM_N   = OW'(-LIMIT);
	localparam logic signed [PW-1:0] HALF    = PW'(ONE / 2);
	localparam logic signed [PW-1:0] HALF_M1 = PW'(ONE / 2 - 1);
	localparam logic [FRAC_BITS:0]   CUT_R   = (FRAC_BITS+1)'(CUT_RST);
	localparam logic [FRAC_BITS:0]   DAMP_R  = (FRAC_BITS+1)'(DAMP_RST);

	logic [FRAC_BITS:0]     cutoff_q;
	logic [FRAC_BITS:0]     damping_q;
	logic signed [OW-1:0]   low1_q;
	logic signed [OW-1:0]   band1_q;
	logic signed [OW-1:0]   low2_q;
	logic signed [OW-1:0]   band2_q;
	logic signed [OW-1:0]   x_q;
	logic signed [OW-1:0]   out_q;
	logic signed [CW-1:0]   f2_q;
	logic signed [CW-1:0]   q2_q;
	logic signed [AW-1:0]   lo_q;
	logic signed [AW-1:0]   hi_q;
	logic signed [PW-1:0]   p_s1;
	logic signed [AW-1:0]   r_s2;

	logic signed [CW-1:0]   a_op;
	logic signed [AW-1:0]   b_op;
	logic signed [PW-1:0]   rnd;
	logic signed [PW-1:0]   rnd_sh;
	logic signed [OW-1:0]   low_sel;
	logic signed [OW-1:0]   band_sel;
	logic signed [AW-1:0]   lo_sum;
	logic signed [AW-1:0]   hi_sum;
	logic signed [AW-1:0]   band_sum;

	function automatic logic signed [OW-1:0] clamp(input logic signed [AW-1:0] v);
		logic signed [OW-1:0] res;
		if (v > AW'(LIM_P)) begin
			res = LIM_P;
		end else if (v < AW'(LIM_N)) begin
			res = LIM_N;
		end else begin
			res = v[OW-1:0];
		end
		return res;
	endfunction

	always_comb begin
		case (cmd.a_sel)
			svflp_pkg::A_CUT:  a_op = $signed({2'b00, cutoff_q});
			svflp_pkg::A_DAMP: a_op = $signed({2'b00, damping_q});
			svflp_pkg::A_F2:   a_op = f2_q;
			svflp_pkg::A_Q2:   a_op = q2_q;
			default:           a_op = f2_q;
		endcase
		case (cmd.b_sel)
			svflp_pkg::B_BAND1: b_op = AW'(band1_q);
			svflp_pkg::B_BAND2: b_op = AW'(band2_q);
			svflp_pkg::B_HI:    b_op = hi_q;
			svflp_pkg::B_KF2:   b_op = KF2_A;
			svflp_pkg::B_KQ2:   b_op = KQ2_A;
			default:            b_op = hi_q;
		endcase
	end

	// round half away from zero
	assign rnd    = p_s1 + (p_s1[PW-1] ? HALF_M1 : HALF);
	assign rnd_sh = rnd >>> FRAC_BITS;

	assign low_sel  = (cmd.sec == svflp_pkg::SEC_TWO) ? low2_q : low1_q;
	assign band_sel = (cmd.sec == svflp_pkg::SEC_TWO) ? band2_q : band1_q;
	assign lo_sum   = AW'(low_sel) + r_s2;
	assign hi_sum   = AW'(x_q) - lo_q - r_s2;
	assign band_sum = AW'(band_sel) + r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q  <= CUT_R;
			damping_q <= DAMP_R;
		end else if (cfg_we) begin
			case (cfg_index)
				svflp_pkg::REG_CUTOFF:  cutoff_q  <= cfg_data;
				svflp_pkg::REG_DAMPING: damping_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low1_q  <= '0;
			band1_q <= '0;
			low2_q  <= '0;
			band2_q <= '0;
			x_q     <= '0;
			out_q   <= '0;
		end else begin
			if (cmd.load) begin
				x_q <= OW'(sample_in);
				if (clear_state) begin
					low1_q  <= '0;
					band1_q <= '0;
					low2_q  <= '0;
					band2_q <= '0;
				end
			end
			if (cmd.op == svflp_pkg::OP_BAND) begin
				if (cmd.sec == svflp_pkg::SEC_ONE) begin
					band1_q <= clamp(band_sum);
					low1_q  <= clamp(lo_q);
					x_q     <= clamp(lo_q);
				end else begin
					band2_q <= clamp(band_sum);
					low2_q  <= clamp(lo_q);
					out_q   <= clamp(lo_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= a_op * b_op;
		r_s2 <= rnd_sh[AW-1:0];
		case (cmd.op)
			svflp_pkg::OP_LOW:  lo_q <= lo_sum;
			svflp_pkg::OP_HIGH: hi_q <= hi_sum;
			svflp_pkg::OP_F2:   f2_q <= r_s2[CW-1:0];
			svflp_pkg::OP_Q2:   q2_q <= r_s2[CW-1:0];
			default: ;
		endcase
	end

	assign lowpass_out = out_q;

endmodule

FILE: hw/rtl/svflp_ctrl.sv
// ----------------------------------------------------------------------------
// svflp_ctrl
// Sequencer: steps the shared multiplier through both sections and runs the
// input and output handshakes.
// ----------------------------------------------------------------------------
`include "two_stage_svf_lowpass_core_assert.svh"

module svflp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output svflp_pkg::cmd_t  cmd
);
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                         state_q;
	logic [svflp_pkg::STEP_W-1:0]   step_q;
	logic                           out_valid_q;
	logic                           blocked;

	assign blocked = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == svflp_pkg::STEP_HOLD && blocked) begin
						step_q <= step_q;
					end else if (step_q == svflp_pkg::STEP_LAST) begin
						state_q <= ST_IDLE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + svflp_pkg::STEP_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_RUN && step_q == svflp_pkg::STEP_LAST) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '{load: 1'b0, a_sel: svflp_pkg::A_F2, b_sel: svflp_pkg::B_HI,
			op: svflp_pkg::OP_NONE, sec: svflp_pkg::SEC_ONE};
		cmd.load  = in_valid && (state_q == ST_IDLE);
		if (state_q == ST_RUN) begin
			case (step_q)
				4'd0: begin
					cmd.a_sel = svflp_pkg::A_CUT;
					cmd.b_sel = svflp_pkg::B_BAND1;
				end
				4'd1: begin
					cmd.a_sel = svflp_pkg::A_DAMP;
					cmd.b_sel = svflp_pkg::B_BAND1;
				end
				4'd2: begin
					cmd.a_sel = svflp_pkg::A_CUT;
					cmd.b_sel = svflp_pkg::B_KF2;
					cmd.op    = svflp_pkg::OP_LOW;
				end
				4'd3: begin
					cmd.a_sel = svflp_pkg::A_DAMP;
					cmd.b_sel = svflp_pkg::B_KQ2;
					cmd.op    = svflp_pkg::OP_HIGH;
				end
				4'd4: begin
					cmd.a_sel = svflp_pkg::A_CUT;
					cmd.b_sel = svflp_pkg::B_HI;
					cmd.op    = svflp_pkg::OP_F2;
				end
				4'd5: begin
					cmd.a_sel = svflp_pkg::A_F2;
					cmd.b_sel = svflp_pkg::B_BAND2;
					cmd.op    = svflp_pkg::OP_Q2;
				end
				4'd6: begin
					cmd.a_sel = svflp_pkg::A_Q2;
					cmd.b_sel = svflp_pkg::B_BAND2;
					cmd.op    = svflp_pkg::OP_BAND;
				end
				4'd7: begin
					cmd.op    = svflp_pkg::OP_LOW;
					cmd.sec   = svflp_pkg::SEC_TWO;
				end
				4'd8: begin
					cmd.op    = svflp_pkg::OP_HIGH;
					cmd.sec   = svflp_pkg::SEC_TWO;
				end
				4'd11: begin
					cmd.op    = svflp_pkg::OP_BAND;
					cmd.sec   = svflp_pkg::SEC_TWO;
				end
				default: ;
			endcase
		end
	end

	`SVFLP_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == ST_RUN && step_q == '0, "accepted item did not start the sequence")
	`SVFLP_ASSERT_NEXT(a_hold_when_blocked, state_q == ST_RUN && step_q == svflp_pkg::STEP_HOLD && blocked, step_q == svflp_pkg::STEP_HOLD, "sequence advanced while result register was occupied")
	`SVFLP_ASSERT_NEXT(a_last_delivers, state_q == ST_RUN && step_q == svflp_pkg::STEP_LAST, out_valid_q && in_ready, "final step did not present a result")
	`SVFLP_ASSERT_SAME(a_no_overwrite, cmd.op == svflp_pkg::OP_BAND && cmd.sec == svflp_pkg::SEC_TWO, !out_valid_q, "result register overwritten before transfer")

endmodule

FILE: hw/rtl/two_stage_svf_lowpass_core.sv
// ----------------------------------------------------------------------------
// two_stage_svf_lowpass_core
// Two cascaded state-variable lowpass sections on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one sample (sample_in, clear_state) per transfer.
//             clear_state zeroes all four integrators before the sample runs.
//   results : source channel, one lowpass_out per accepted sample, in order.
//   cfg     : write cfg_data to register cfg_index while cfg_we is high:
//             index 0 cutoff coefficient, index 1 damping coefficient.
//             Write only while no sample is in flight.
// Sequence:
//   A sample runs 12 steps through one multiplier and a rounding register;
//   its last step loads the result register and sets results.valid. The
//   next sample is taken only after the previous one finishes all steps.
//   samples.ready is high only between items.
// Stall:
//   A waiting result stays in the output register while the next sample is
//   taken and runs; that sample pauses at step 9 until the register is free.
// Reset:
//   arst_n clears integrators and handshake state and loads the default
//   coefficients.
// ----------------------------------------------------------------------------
module two_stage_svf_lowpass_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [svflp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [FRAC_BITS:0]                cfg_data,
	svflp_sample_if.sink                      samples,
	svflp_result_if.source                    results
);
	svflp_pkg::cmd_t cmd;

	svflp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	svflp_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_in   (samples.sample_in),
		.clear_state (samples.clear_state),
		.lowpass_out (results.lowpass_out)
	);

endmodule
